>>> design/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg: shared types and constants for the link-state table
// Table depth, op and status codes, queued item layout, back-end states.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DUMP_MAX    = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;

    localparam logic [15:0] MAX_AGE_RST = 16'd3600;
    localparam logic [5:0]  REMOVED_SAT = 6'd63;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_TICK   = 2'd1,
        OP_DUMP   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_STALE    = 3'd2,
        ST_FULL     = 3'd3,
        ST_INFO     = 3'd4
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [31:0] rid;
        logic [31:0] sub;
        logic [31:0] msk;
        logic [31:0] seq;
        logic [15:0] age;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AGE,
        S_SCAN,
        S_TICK_DONE,
        S_DUMP
    } t_state;

endpackage

>>> design/lst_front.sv
// ----------------------------------------------------------------------------
// lst_front: input intake and decode
// Takes input beats, decodes the op and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lst_front import lst_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [143:0]  s_axis_tdata,   // rid, subnet, mask, seq, age
    input  logic [1:0]    s_axis_tuser,   // op
    output t_queue_head   o_head,
    input  logic          i_pop
);

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    t_item       w_in;
    logic        w_push;

    always_comb begin
        w_in.op  = t_op'(s_axis_tuser);
        w_in.rid = s_axis_tdata[31:0];
        w_in.sub = s_axis_tdata[63:32];
        w_in.msk = s_axis_tdata[95:64];
        w_in.seq = s_axis_tdata[127:96];
        w_in.age = s_axis_tdata[143:128];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_head.valid  = (r_cnt != 2'd0);
    assign o_head.item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> design/lst_back.sv
// ----------------------------------------------------------------------------
// lst_back: table engine and result register
// Holds the ordered entry table, runs update, aging sweep and dump.
// ----------------------------------------------------------------------------
module lst_back import lst_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    input  t_queue_head   i_head,
    output logic          o_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [151:0]  m_axis_tdata,   // removed_count, rid, subnet, mask, seq, age, pad
    output logic [3:0]    m_axis_tuser,   // status, entry_present
    output logic          m_axis_tlast
);

    // entry table, one cell per position, position 0 newest
    logic        r_vld [TABLE_DEPTH];
    logic [31:0] r_rid [TABLE_DEPTH];
    logic [31:0] r_sub [TABLE_DEPTH];
    logic [31:0] r_msk [TABLE_DEPTH];
    logic [31:0] r_seq [TABLE_DEPTH];
    logic [15:0] r_age [TABLE_DEPTH];
    logic [31:0] r_stp [TABLE_DEPTH];

    logic [31:0] r_now;
    logic [15:0] r_max_age;
    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_idx;
    logic [5:0]  r_removed;

    // result register
    logic        r_ovld;
    t_status     r_ostat;
    logic        r_opres;
    logic [5:0]  r_orem;
    logic [31:0] r_orid, r_osub, r_omsk, r_oseq;
    logic [15:0] r_oage;
    logic        r_olast;

    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_gt;
    logic        w_any_hit, w_newer, w_full;
    logic        w_can_emit;
    logic [IDX_W-1:0] w_rd;
    logic        w_in_range, w_rd_vld, w_nxt_vld, w_expired, w_dump_last;
    t_item       w_it;

    // control from the sequencer
    logic        c_emit, c_upd_write, c_insert, c_now_inc, c_age_calc;
    logic        c_shift_dn, c_idx_inc, c_idx_clr;
    t_status     c_stat;
    logic        c_pres, c_last;
    logic [5:0]  c_rem;

    assign w_it = i_head.item;

    always_comb begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            w_hit[j] = r_vld[j] && (r_rid[j] == w_it.rid) && (r_sub[j] == w_it.sub);
            w_gt[j]  = w_it.seq > r_seq[j];
        end
    end

    assign w_any_hit  = |w_hit;
    assign w_newer    = |(w_hit & w_gt);
    assign w_full     = r_vld[TABLE_DEPTH-1];
    assign w_can_emit = !r_ovld || m_axis_tready;

    assign w_rd        = r_idx[IDX_W-1:0];
    assign w_in_range  = r_idx < CNT_W'(TABLE_DEPTH);
    assign w_rd_vld    = w_in_range && r_vld[w_rd];
    assign w_expired   = r_age[w_rd] >= r_max_age;
    assign w_nxt_vld   = (w_rd == IDX_W'(TABLE_DEPTH - 1)) ? 1'b0 : r_vld[w_rd + 1'b1];
    assign w_dump_last = !w_nxt_vld || (r_idx == CNT_W'(DUMP_MAX - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (w_it.op)
                        OP_TICK: n_state = S_AGE;
                        OP_DUMP: n_state = S_DUMP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_AGE:       n_state = S_SCAN;
            S_SCAN:      if (!w_rd_vld) n_state = S_TICK_DONE;
            S_TICK_DONE: if (w_can_emit) n_state = S_IDLE;
            S_DUMP:      if (w_can_emit && (!w_rd_vld || w_dump_last)) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_pop       = 1'b0;
        c_emit      = 1'b0;
        c_upd_write = 1'b0;
        c_insert    = 1'b0;
        c_now_inc   = 1'b0;
        c_age_calc  = 1'b0;
        c_shift_dn  = 1'b0;
        c_idx_inc   = 1'b0;
        c_idx_clr   = 1'b0;
        c_stat      = ST_INFO;
        c_pres      = 1'b0;
        c_last      = 1'b1;
        c_rem       = 6'd0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (w_it.op)
                        OP_UPDATE: begin
                            if (w_can_emit) begin
                                o_pop  = 1'b1;
                                c_emit = 1'b1;
                                if (w_any_hit) begin
                                    c_upd_write = w_newer;
                                    c_stat      = w_newer ? ST_UPDATED : ST_STALE;
                                end else if (w_full) begin
                                    c_stat = ST_FULL;
                                end else begin
                                    c_insert = 1'b1;
                                    c_stat   = ST_INSERTED;
                                end
                            end
                        end
                        OP_TICK: begin
                            o_pop     = 1'b1;
                            c_now_inc = 1'b1;
                        end
                        OP_DUMP: begin
                            o_pop     = 1'b1;
                            c_idx_clr = 1'b1;
                        end
                        default: begin
                            if (w_can_emit) begin
                                o_pop  = 1'b1;
                                c_emit = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_AGE: begin
                c_age_calc = 1'b1;
                c_idx_clr  = 1'b1;
            end
            S_SCAN: begin
                if (w_rd_vld) begin
                    if (w_expired) c_shift_dn = 1'b1;
                    else           c_idx_inc  = 1'b1;
                end
            end
            S_TICK_DONE: begin
                c_emit = w_can_emit;
                c_rem  = r_removed;
            end
            S_DUMP: begin
                if (w_can_emit) begin
                    c_emit    = 1'b1;
                    c_pres    = w_rd_vld;
                    c_last    = !w_rd_vld || w_dump_last;
                    c_idx_inc = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= '0;
            r_max_age <= MAX_AGE_RST;
            r_idx     <= '0;
            r_removed <= '0;
            r_ovld    <= 1'b0;
            for (int j = 0; j < TABLE_DEPTH; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_max_age <= i_cfg_wr_data;
            if (c_now_inc) begin
                r_now     <= r_now + 32'd1;
                r_removed <= '0;
            end
            if (c_idx_clr)      r_idx <= '0;
            else if (c_idx_inc) r_idx <= r_idx + 1'b1;
            if (c_shift_dn && r_removed != REMOVED_SAT) r_removed <= r_removed + 6'd1;
            if (c_emit)              r_ovld <= 1'b1;
            else if (m_axis_tready)  r_ovld <= 1'b0;
            // valid bits
            if (c_insert) begin
                for (int j = TABLE_DEPTH - 1; j > 0; j--) r_vld[j] <= r_vld[j-1];
                r_vld[0] <= 1'b1;
            end else if (c_shift_dn) begin
                for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
                    if (IDX_W'(j) >= w_rd) r_vld[j] <= r_vld[j+1];
                end
                r_vld[TABLE_DEPTH-1] <= 1'b0;
            end
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (c_insert) begin
            for (int j = TABLE_DEPTH - 1; j > 0; j--) begin
                r_rid[j] <= r_rid[j-1];
                r_sub[j] <= r_sub[j-1];
                r_msk[j] <= r_msk[j-1];
                r_seq[j] <= r_seq[j-1];
                r_age[j] <= r_age[j-1];
                r_stp[j] <= r_stp[j-1];
            end
            r_rid[0] <= w_it.rid;
            r_sub[0] <= w_it.sub;
            r_msk[0] <= w_it.msk;
            r_seq[0] <= w_it.seq;
            r_age[0] <= w_it.age;
            r_stp[0] <= r_now;
        end else if (c_upd_write) begin
            for (int j = 0; j < TABLE_DEPTH; j++) begin
                if (w_hit[j]) begin
                    r_msk[j] <= w_it.msk;
                    r_seq[j] <= w_it.seq;
                    r_age[j] <= w_it.age;
                    r_stp[j] <= r_now;
                end
            end
        end else if (c_age_calc) begin
            for (int j = 0; j < TABLE_DEPTH; j++) begin
                logic [31:0] diff;
                diff = r_now - r_stp[j];
                r_age[j] <= (diff[31:16] != 16'd0) ? 16'hFFFF : diff[15:0];
            end
        end else if (c_shift_dn) begin
            for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
                if (IDX_W'(j) >= w_rd) begin
                    r_rid[j] <= r_rid[j+1];
                    r_sub[j] <= r_sub[j+1];
                    r_msk[j] <= r_msk[j+1];
                    r_seq[j] <= r_seq[j+1];
                    r_age[j] <= r_age[j+1];
                    r_stp[j] <= r_stp[j+1];
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_ostat <= c_stat;
            r_opres <= c_pres;
            r_orem  <= c_rem;
            r_olast <= c_last;
            r_orid  <= c_pres ? r_rid[w_rd] : 32'd0;
            r_osub  <= c_pres ? r_sub[w_rd] : 32'd0;
            r_omsk  <= c_pres ? r_msk[w_rd] : 32'd0;
            r_oseq  <= c_pres ? r_seq[w_rd] : 32'd0;
            r_oage  <= c_pres ? r_age[w_rd] : 16'd0;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {2'b00, r_oage, r_oseq, r_omsk, r_osub, r_orid, r_orem};
    assign m_axis_tuser  = {r_opres, r_ostat};
    assign m_axis_tlast  = r_olast;

endmodule

>>> design/link_state_table_with_aging.sv
// ----------------------------------------------------------------------------
// link_state_table_with_aging: link-state entry table with aging
// Ordered table of entries keyed by router ID and subnet, with update,
// one-second aging tick and dump.
// ----------------------------------------------------------------------------
// Usage: an update beat matches its key against all entries at once (status
// inserted, updated, stale or full); a tick recomputes all ages, then a
// one-entry-per-cycle compaction sweep keeps or removes each entry; a dump
// gives one result beat per entry, one per cycle when not stalled, up to 32,
// the final one with tlast. Each op 3 beat gives a single info result. A
// two-beat input queue lets new beats in while the engine works, and a result
// register lets a tick's sweep run while a result waits. The user must
// write max_age via i_cfg_wr_en/i_cfg_wr_data when idle; not enforced.
module link_state_table_with_aging import lst_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,    // max_age
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [143:0]  s_axis_tdata,     // rtr_id, subnet, mask, seq, age
    input  logic [1:0]    s_axis_tuser,     // op
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [151:0]  m_axis_tdata,     // removed_count, out_rtr_id,
                                            // out_subnet, out_mask, out_seq,
                                            // out_age, zero pad
    output logic [3:0]    m_axis_tuser,     // status, entry_present
    output logic          m_axis_tlast      // last
);

    t_queue_head w_head;
    logic        w_pop;

    lst_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head        (w_head),
        .i_pop         (w_pop)
    );

    lst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
